// File: hdl/mhdv_pkg.sv
// Shared constants, codes and controller/datapath interface types for the heap block.
`timescale 1ns / 1ps

package mhdv_pkg;

    localparam int HEAP_CAPACITY = 64;
    localparam int HEAP_KEY_BITS = 32;

    localparam int KEY_W    = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] dp_op_t;

    localparam dp_op_t OP_NOP       = 4'd0;
    localparam dp_op_t OP_LOAD      = 4'd1;
    localparam dp_op_t OP_APPEND    = 4'd2;
    localparam dp_op_t OP_FULL      = 4'd3;
    localparam dp_op_t OP_RANGE     = 4'd4;
    localparam dp_op_t OP_READ      = 4'd5;
    localparam dp_op_t OP_SCAN      = 4'd6;
    localparam dp_op_t OP_MISS      = 4'd7;
    localparam dp_op_t OP_DROP_LAST = 4'd8;
    localparam dp_op_t OP_FETCH     = 4'd9;
    localparam dp_op_t OP_PLACE     = 4'd10;
    localparam dp_op_t OP_UP        = 4'd11;
    localparam dp_op_t OP_DOWN_RD   = 4'd12;
    localparam dp_op_t OP_DOWN      = 4'd13;
    localparam dp_op_t OP_SETTLE    = 4'd14;
    localparam dp_op_t OP_EMIT      = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pos_bad;
        logic             hit;
        logic             miss;
        logic             found_last;
        logic             at_root;
        logic             up_move;
        logic             moved;
        logic             down_stop;
        logic             out_free;
    } dp_status_t;

endpackage

// File: hdl/min_heap_delete_by_value.sv
// Channel    Direction  Ports
// s_ (cmd)   in         s_valid, s_ready, s_cmd, s_key, s_position
// m_ (resp)  out        m_valid, m_ready, m_status, m_entry_count, m_found_at, m_read_key
//
// Append, read and unused commands go from accept through the decode and emit states to the result.
// Delete scans one position per cycle. A hit before the last position moves the last key into the
// freed position and sifts it up or down, one heap level per step.
// The store has one write port and two read ports.
// Reset clears the count and the result valid flag; store contents stay undefined.
// A new transaction is accepted while the last result waits; the block holds before
// loading the next result until the output register is free.
`timescale 1ns / 1ps

module min_heap_delete_by_value #(
    parameter int CAPACITY = mhdv_pkg::HEAP_CAPACITY,
    parameter int KEY_BITS = mhdv_pkg::HEAP_KEY_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mhdv_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [mhdv_pkg::KEY_W-1:0]    s_key,
    input  logic [mhdv_pkg::POS_W-1:0]           s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mhdv_pkg::STATUS_W-1:0]        m_status,
    output logic [mhdv_pkg::COUNT_W-1:0]         m_entry_count,
    output logic [mhdv_pkg::COUNT_W-1:0]         m_found_at,
    output logic signed [mhdv_pkg::KEY_W-1:0]    m_read_key
);
    import mhdv_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    mhdv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .op      (op)
    );

    mhdv_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op            (op),
        .status        (status),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_position    (s_position),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count),
        .m_found_at    (m_found_at),
        .m_read_key    (m_read_key)
    );

endmodule

// File: hdl/mhdv_datapath.sv
// Heap store, count, search and sift registers, and the result register.
`timescale 1ns / 1ps

module mhdv_datapath #(
    parameter int CAPACITY = mhdv_pkg::HEAP_CAPACITY,
    parameter int KEY_BITS = mhdv_pkg::HEAP_KEY_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mhdv_pkg::dp_op_t                     op,
    output mhdv_pkg::dp_status_t                 status,
    input  logic [mhdv_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [mhdv_pkg::KEY_W-1:0]    s_key,
    input  logic [mhdv_pkg::POS_W-1:0]           s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mhdv_pkg::STATUS_W-1:0]        m_status,
    output logic [mhdv_pkg::COUNT_W-1:0]         m_entry_count,
    output logic [mhdv_pkg::COUNT_W-1:0]         m_found_at,
    output logic signed [mhdv_pkg::KEY_W-1:0]    m_read_key
);
    import mhdv_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int PW     = CNT_W + 1;
    localparam int PCW    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] CNT_ONE = 1;
    localparam logic [PW-1:0]    P_ONE   = 1;

    typedef logic signed [KEY_BITS-1:0] key_t;

    key_t mem [CAPACITY];

    key_t rdata_a_reg, rdata_b_reg;
    key_t key_reg, key_next;
    key_t val_reg, val_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PW-1:0]       scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    cmp_pos_reg, cmp_pos_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    logic [CNT_W-1:0]    cur_reg, cur_next;
    logic                moved_reg, moved_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;
    logic [COUNT_W-1:0]  m_found_reg, m_found_next;
    logic [KEY_W-1:0]    m_key_reg, m_key_next;

    logic              wr_en, rd_en_a, rd_en_b;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    key_t              wr_data;

    logic [PW-1:0]    cnt_ext, l_pos, r_pos, bl_pos;
    logic             take_l, take_r;
    key_t             lv, best_val;
    logic [CNT_W-1:0] best_pos;

    always_comb begin
        cnt_ext  = {1'b0, count_reg};
        l_pos    = {cur_reg, 1'b0};
        r_pos    = {cur_reg, 1'b1};
        take_l   = (l_pos <= cnt_ext) && (rdata_a_reg < val_reg);
        lv       = take_l ? rdata_a_reg : val_reg;
        take_r   = (r_pos <= cnt_ext) && (rdata_b_reg < lv);
        best_val = take_r ? rdata_b_reg : lv;
        best_pos = take_r ? CNT_W'(r_pos) : (take_l ? CNT_W'(l_pos) : cur_reg);
        bl_pos   = {best_pos, 1'b0};
    end

    always_comb begin
        status.cmd        = cmd_reg;
        status.full       = (count_reg == CNT_W'(CAPACITY));
        status.pos_bad    = (pos_reg == '0) || (PCW'(pos_reg) > PCW'(count_reg));
        status.hit        = pend_reg && (rdata_a_reg == key_reg);
        status.miss       = !pend_reg && (scan_reg > cnt_ext);
        status.found_last = (cmp_pos_reg == count_reg);
        status.at_root    = (found_reg == CNT_ONE);
        status.up_move    = (cur_reg > CNT_ONE) && (val_reg < rdata_a_reg);
        status.moved      = moved_reg;
        status.down_stop  = !take_l && !take_r;
        status.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        key_next        = key_reg;
        val_next        = val_reg;
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        cmp_pos_next    = cmp_pos_reg;
        found_next      = found_reg;
        cur_next        = cur_reg;
        moved_next      = moved_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;
        m_found_next    = m_found_reg;
        m_key_next      = m_key_reg;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(cur_reg - CNT_ONE);
        wr_data         = val_reg;
        rd_en_a         = 1'b0;
        rd_en_b         = 1'b0;
        rd_addr_a       = ADDR_W'(l_pos - P_ONE);
        rd_addr_b       = ADDR_W'(l_pos);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (op)
            OP_LOAD: begin
                cmd_next        = s_cmd;
                key_next        = KEY_BITS'($unsigned(s_key));
                pos_next        = s_position;
                scan_next       = P_ONE;
                pend_next       = 1'b0;
                found_next      = '0;
                res_status_next = STAT_DONE;
            end
            OP_APPEND: begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(count_reg);
                wr_data    = key_reg;
                count_next = count_reg + CNT_ONE;
            end
            OP_FULL: begin
                res_status_next = STAT_FULL;
            end
            OP_RANGE: begin
                res_status_next = STAT_RANGE;
            end
            OP_READ: begin
                rd_en_a   = 1'b1;
                rd_addr_a = ADDR_W'(pos_reg - POS_W'(1));
            end
            OP_SCAN: begin
                rd_en_a      = 1'b1;
                rd_addr_a    = ADDR_W'(scan_reg - P_ONE);
                pend_next    = (scan_reg <= cnt_ext);
                cmp_pos_next = CNT_W'(scan_reg);
                scan_next    = scan_reg + P_ONE;
            end
            OP_MISS: begin
                res_status_next = STAT_NOT_FOUND;
            end
            OP_DROP_LAST: begin
                found_next = cmp_pos_reg;
                count_next = count_reg - CNT_ONE;
            end
            OP_FETCH: begin
                found_next = cmp_pos_reg;
                count_next = count_reg - CNT_ONE;
                rd_en_a    = 1'b1;
                rd_addr_a  = ADDR_W'(count_reg - CNT_ONE);
            end
            OP_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_W'(found_reg - CNT_ONE);
                wr_data    = rdata_a_reg;
                val_next   = rdata_a_reg;
                cur_next   = found_reg;
                moved_next = 1'b0;
                rd_en_a    = 1'b1;
                rd_addr_a  = ADDR_W'((found_reg >> 1) - CNT_ONE);
            end
            OP_UP: begin
                wr_en      = 1'b1;
                wr_data    = rdata_a_reg;
                cur_next   = cur_reg >> 1;
                moved_next = 1'b1;
                rd_en_a    = 1'b1;
                rd_addr_a  = ADDR_W'((cur_reg >> 2) - CNT_ONE);
            end
            OP_DOWN_RD: begin
                rd_en_a = 1'b1;
                rd_en_b = 1'b1;
            end
            OP_DOWN: begin
                wr_en     = 1'b1;
                wr_data   = best_val;
                cur_next  = best_pos;
                rd_en_a   = 1'b1;
                rd_en_b   = 1'b1;
                rd_addr_a = ADDR_W'(bl_pos - P_ONE);
                rd_addr_b = ADDR_W'(bl_pos);
            end
            OP_SETTLE: begin
                wr_en = 1'b1;
            end
            OP_EMIT: begin
                m_valid_next  = 1'b1;
                m_status_next = res_status_reg;
                m_count_next  = COUNT_W'(count_reg);
                m_found_next  = COUNT_W'(found_reg);
                if (cmd_reg == CMD_READ && res_status_reg == STAT_DONE) begin
                    m_key_next = KEY_W'($unsigned(rdata_a_reg));
                end else begin
                    m_key_next = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            rdata_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b) begin
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg        <= key_next;
        val_reg        <= val_next;
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        scan_reg       <= scan_next;
        pend_reg       <= pend_next;
        cmp_pos_reg    <= cmp_pos_next;
        found_reg      <= found_next;
        cur_reg        <= cur_next;
        moved_reg      <= moved_next;
        res_status_reg <= res_status_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        m_found_reg    <= m_found_next;
        m_key_reg      <= m_key_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;
    assign m_found_at    = m_found_reg;
    assign m_read_key    = m_key_reg;

endmodule

// File: hdl/mhdv_ctrl.sv
// Command sequencer: decode, linear search, sift up and sift down, result hand-off.
`timescale 1ns / 1ps

module mhdv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mhdv_pkg::dp_status_t status,
    output mhdv_pkg::dp_op_t     op
);
    import mhdv_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_SEARCH  = 3'd2;
    localparam logic [2:0] ST_PLACE   = 3'd3;
    localparam logic [2:0] ST_UP      = 3'd4;
    localparam logic [2:0] ST_DOWN_RD = 3'd5;
    localparam logic [2:0] ST_DOWN    = 3'd6;
    localparam logic [2:0] ST_EMIT    = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        s_ready    = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.cmd)
                    CMD_APPEND: begin
                        op         = status.full ? OP_FULL : OP_APPEND;
                        state_next = ST_EMIT;
                    end
                    CMD_READ: begin
                        op         = status.pos_bad ? OP_RANGE : OP_READ;
                        state_next = ST_EMIT;
                    end
                    CMD_DELETE: begin
                        state_next = ST_SEARCH;
                    end
                    default: begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_SEARCH: begin
                priority if (status.hit) begin
                    if (status.found_last) begin
                        op         = OP_DROP_LAST;
                        state_next = ST_EMIT;
                    end else begin
                        op         = OP_FETCH;
                        state_next = ST_PLACE;
                    end
                end else if (status.miss) begin
                    op         = OP_MISS;
                    state_next = ST_EMIT;
                end else begin
                    op = OP_SCAN;
                end
            end
            ST_PLACE: begin
                op         = OP_PLACE;
                state_next = status.at_root ? ST_DOWN_RD : ST_UP;
            end
            ST_UP: begin
                priority if (status.up_move) begin
                    op = OP_UP;
                end else if (status.moved) begin
                    op         = OP_SETTLE;
                    state_next = ST_EMIT;
                end else begin
                    op         = OP_DOWN_RD;
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN_RD: begin
                op         = OP_DOWN_RD;
                state_next = ST_DOWN;
            end
            ST_DOWN: begin
                if (status.down_stop) begin
                    op         = OP_SETTLE;
                    state_next = ST_EMIT;
                end else begin
                    op = OP_DOWN;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    op         = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the min-heap block with append, delete-by-value and read.
`timescale 1ns / 1ps

module tb;
    import mhdv_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] position;
    } heap_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  entry_count;
        logic [COUNT_W-1:0]  found_at;
        logic [KEY_W-1:0]    read_key;
    } heap_resp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_cmd = CMD_APPEND;
    logic signed [KEY_W-1:0] s_key = '0;
    logic [POS_W-1:0] s_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [COUNT_W-1:0] m_entry_count;
    logic [COUNT_W-1:0] m_found_at;
    logic signed [KEY_W-1:0] m_read_key;

    min_heap_delete_by_value uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_key(s_key),
        .s_position(s_position),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_entry_count(m_entry_count),
        .m_found_at(m_found_at),
        .m_read_key(m_read_key)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    heap_cmd_t cmd_pending[$];
    heap_resp_t resp_expected[$];
    logic [KEY_W-1:0] key_history[$];
    heap_cmd_t cur_cmd;
    bit in_taken = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int err_count = 0;
    int n_accepted = 0;
    int n_checked = 0;

    // predictor state
    logic signed [KEY_W-1:0] heap_keys[1:HEAP_CAPACITY];
    int heap_size = 0;
    int peak_size = 0;
    int n_hits = 0, n_miss = 0, n_full = 0, n_range = 0, n_up = 0, n_down = 0, n_reads = 0;

    function automatic void heap_swap(int a, int b);
        logic signed [KEY_W-1:0] t;
        t = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic heap_resp_t heap_apply(heap_cmd_t it);
        heap_resp_t r;
        int i, hit, p, best;
        bit moving;
        r = '0;
        case (it.cmd)
            CMD_APPEND: begin
                if (heap_size >= HEAP_CAPACITY) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    heap_size++;
                    heap_keys[heap_size] = it.key;
                    if (heap_size > peak_size) peak_size = heap_size;
                end
            end
            CMD_DELETE: begin
                hit = 0;
                for (i = 1; i <= heap_size && hit == 0; i++)
                    if (heap_keys[i] == $signed(it.key)) hit = i;
                if (hit == 0) begin
                    r.status = STAT_NOT_FOUND;
                    n_miss++;
                end else begin
                    n_hits++;
                    r.found_at = COUNT_W'(hit);
                    heap_keys[hit] = heap_keys[heap_size];
                    heap_size--;
                    p = hit;
                    if (p <= heap_size) begin
                        if (p > 1 && heap_keys[p] < heap_keys[p / 2]) begin
                            n_up++;
                            while (p > 1 && heap_keys[p] < heap_keys[p / 2]) begin
                                heap_swap(p, p / 2);
                                p = p / 2;
                            end
                        end else begin
                            moving = 1'b1;
                            while (moving) begin
                                best = p;
                                if (2 * p <= heap_size && heap_keys[2 * p] < heap_keys[best])
                                    best = 2 * p;
                                if (2 * p + 1 <= heap_size
                                        && heap_keys[2 * p + 1] < heap_keys[best])
                                    best = 2 * p + 1;
                                if (best == p) begin
                                    moving = 1'b0;
                                end else begin
                                    if (p == hit) n_down++;
                                    heap_swap(p, best);
                                    p = best;
                                end
                            end
                        end
                    end
                end
            end
            CMD_READ: begin
                if (it.position == 0 || it.position > heap_size) begin
                    r.status = STAT_RANGE;
                    n_range++;
                end else begin
                    r.read_key = heap_keys[it.position];
                    n_reads++;
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(heap_size);
        return r;
    endfunction

    function automatic heap_cmd_t cmd_of(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k,
                                         logic [POS_W-1:0] p);
        heap_cmd_t it;
        it.cmd = c;
        it.key = k;
        it.position = p;
        return it;
    endfunction

    function automatic heap_cmd_t make_item(int append_pct, bit narrow);
        heap_cmd_t it;
        int roll;
        it.cmd = CMD_READ;
        it.key = $urandom;
        it.position = POS_W'($urandom_range(1, HEAP_CAPACITY));
        if (narrow) it.key = $urandom_range(0, 15) - 8;
        roll = $urandom_range(0, 99);
        if (roll < append_pct) begin
            it.cmd = CMD_APPEND;
            key_history.push_back(it.key);
            if (key_history.size() > 96) void'(key_history.pop_front());
        end else if (roll < append_pct + (100 - append_pct) * 3 / 5) begin
            it.cmd = CMD_DELETE;
            if (key_history.size() != 0 && $urandom_range(0, 9) < 8)
                it.key = key_history[$urandom_range(0, key_history.size() - 1)];
        end else if (roll < 98) begin
            if ($urandom_range(0, 1)) it.position = POS_W'($urandom_range(1, 16));
        end else begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    // accept and check on the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            resp_expected.push_back(heap_apply(cur_cmd));
            in_taken = 1'b1;
            n_accepted++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (resp_expected.size() == 0) begin
                $error("unexpected result: status %0d count %0d", m_status, m_entry_count);
                err_count++;
            end else begin
                heap_resp_t want;
                want = resp_expected.pop_front();
                n_checked++;
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    err_count++;
                end
                if (m_entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_entry_count);
                    err_count++;
                end
                if (m_found_at !== want.found_at) begin
                    $error("found_at: expected %0d, got %0d", want.found_at, m_found_at);
                    err_count++;
                end
                if (m_read_key !== $signed(want.read_key)) begin
                    $error("read_key: expected %0d, got %0d",
                           $signed(want.read_key), m_read_key);
                    err_count++;
                end
            end
        end
    end

    // drive the input channel on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            in_taken = 1'b0;
            if (cmd_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                cur_cmd = cmd_pending.pop_front();
                s_valid <= 1'b1;
                s_cmd <= cur_cmd.cmd;
                s_key <= cur_cmd.key;
                s_position <= cur_cmd.position;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // drive the result-side ready, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd1));
        cmd_pending.push_back(cmd_of(CMD_UNUSED, 32'hFFFF_FFFF, 7'd127));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'd0, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd0, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd10, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd1, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd11, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd12, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd2, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'd3, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'd11, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'h7FFF_FFFF, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_APPEND, 32'h8000_0000, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd64));
        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd8));
        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd1));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'h8000_0000, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'd0, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'd99, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_DELETE, 32'h7FFF_FFFF, 7'd0));
        cmd_pending.push_back(cmd_of(CMD_READ, 32'd0, 7'd2));
        while (cmd_pending.size() != 0) @(negedge aclk);

        for (int m = 0; m < 4; m++) begin
            src_idle_pct = (m == 1) ? 45 : (m == 3) ? 23 : 0;
            sink_idle_pct = (m == 2) ? 45 : (m == 3) ? 23 : 0;
            if (m == 0) hold_request = 1'b1;
            for (int b = 0; b < 250; b++)
                cmd_pending.push_back(make_item((b < 100) ? 85 : 25, m[0]));
            while (cmd_pending.size() != 0) @(negedge aclk);
        end

        while (s_valid || resp_expected.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("%0d transactions, %0d results checked; deletes: %0d hit (%0d up, %0d down)",
                 n_accepted, n_checked, n_hits, n_up, n_down);
        $display("%0d missed deletes, %0d full rejects, %0d reads, %0d out-of-range reads, peak %0d",
                 n_miss, n_full, n_reads, n_range, peak_size);
        if (err_count == 0 && resp_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: min_heap_delete_by_value.f
hdl/mhdv_pkg.sv
hdl/mhdv_datapath.sv
hdl/mhdv_ctrl.sv
hdl/min_heap_delete_by_value.sv
tb/tb.sv
